>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked-property helpers for the deframer assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true on a clock edge.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_PROP(lbl, !(expr), msg)

`endif

>>> rtl/pld_pkg.sv
// ----------------------------------------------------------------------------
// pld_pkg
// Types, codes and helpers shared by the pkt-line deframer modules.
// ----------------------------------------------------------------------------
package pld_pkg;

  // result kind codes
  typedef enum logic [2:0] {
    KIND_PAYLOAD     = 3'd0,
    KIND_FLUSH       = 3'd1,
    KIND_DELIM       = 3'd2,
    KIND_EMPTY       = 3'd3,
    KIND_BAD_DIGIT   = 3'd4,
    KIND_BAD_LENGTH  = 3'd5,
    KIND_BAD_CHANNEL = 3'd6,
    KIND_EMPTY_SB    = 3'd7
  } kind_e;

  // configuration register indexes
  localparam logic CFG_LEN_LIMIT     = 1'b0;
  localparam logic CFG_SIDEBAND_MODE = 1'b1;

  localparam logic [15:0] LEN_LIMIT_RST = 16'd65520;
  localparam logic [15:0] HDR_LEN       = 16'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } item_t;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] payload_byte;
    logic [1:0] channel;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  // ASCII hex digit decode, upper or lower case
  function automatic hex_t hex_decode(logic [7:0] b);
    hex_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.value = b[3:0];
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      r.value = 4'(b[2:0] + 3'd1) + 4'd8;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> rtl/pkt_line_deframer_core.sv
// ----------------------------------------------------------------------------
// pkt_line_deframer_core
// Splits a byte stream into pkt-line frames and reports frame events.
// ----------------------------------------------------------------------------
// One byte per item, one item per cycle sustained. Each byte is latched in an
// input register, decoded by a single pass of header/payload logic against the
// frame state, and any result lands in an output register, so each result
// passes through both registers in turn. The input register refills in the
// same cycle it drains, so a stalled output only stops intake once both
// registers hold an item. Headers are four hex digits giving the frame length
// including the header; 0000 is a flush, 0001 a delimiter, 0004 an empty
// frame. Bad digits or bad lengths halt the block until an item with restart
// set. In side-band mode the first payload byte selects channel 1..3; a bad
// channel drops the rest of the frame. Config writes take effect at once and
// are expected only while no item is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pkt_line_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [1:0]  channel_o,
  output logic        last_o
);
  import pld_pkg::*;

  // config registers
  logic [15:0] len_limit_q;
  logic        sideband_mode_q;

  item_t   in_item;
  item_t   stage_item;
  logic    stage_vld;
  logic    advance;
  result_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_limit_q     <= LEN_LIMIT_RST;
      sideband_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEN_LIMIT:     len_limit_q     <= cfg_wdata_i;
        CFG_SIDEBAND_MODE: sideband_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign in_item.data_byte = data_byte_i;
  assign in_item.restart   = restart_i;

  // held item moves on when the result register is free or being drained
  assign advance = stage_vld && (!out_valid_o || out_ready_i);

  pld_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .vld_o      (stage_vld),
    .item_o     (stage_item)
  );

  pld_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .item_i          (stage_item),
    .len_limit_i     (len_limit_q),
    .sideband_mode_i (sideband_mode_q),
    .result_o        (result)
  );

  pld_out_stage u_out_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .result_i       (result),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .channel_o      (channel_o),
    .last_o         (last_o)
  );

  // non-payload results are single-beat events with no data
  `ASSERT_PROP(a_event_shape, (out_valid_o && kind_o != KIND_PAYLOAD) |-> (last_o && payload_byte_o == 8'd0 && channel_o == 2'd0), "event result carries data or lacks last")
  // an empty result register never back-pressures the input
  `ASSERT_PROP(a_ready_when_empty, !out_valid_o |-> in_ready_o, "input stalled with empty output")
  // a fresh result only comes from an item held in the input register
  `ASSERT_PROP(a_result_source, (out_valid_o && !$past(out_valid_o)) |-> $past(stage_vld), "result without a held item")

endmodule

>>> rtl/pld_in_stage.sv
// ----------------------------------------------------------------------------
// pld_in_stage
// Input register: holds one item until the engine consumes it.
// ----------------------------------------------------------------------------
module pld_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pld_pkg::item_t item_i,
  input  logic          advance_i,
  output logic          vld_o,
  output pld_pkg::item_t item_o
);
  import pld_pkg::*;

  logic  vld_q;
  item_t item_q;

  // free when empty or when the held item moves on this cycle
  assign in_ready_o = !vld_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

>>> rtl/pld_engine.sv
// ----------------------------------------------------------------------------
// pld_engine
// Frame state and combinational next-state / result logic.
// ----------------------------------------------------------------------------
module pld_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  pld_pkg::item_t   item_i,
  input  logic [15:0]      len_limit_i,
  input  logic             sideband_mode_i,
  output pld_pkg::result_t result_o
);
  import pld_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_CHANNEL = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_DROP    = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [1:0]  digit_cnt_q, digit_cnt_d;
  logic [15:0] frame_len_q, frame_len_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [1:0]  cur_chan_q, cur_chan_d;
  logic        halted_q, halted_d;

  logic [1:0]  ph;
  logic [15:0] left;
  logic [15:0] left_m1;
  logic [15:0] new_len;
  hex_t        hex;
  result_t     res;

  always_comb begin
    // restart abandons any open frame and clears halt
    ph           = item_i.restart ? PH_HEADER : phase_q;
    left         = item_i.restart ? 16'd0 : bytes_left_q;
    left_m1      = left - 16'd1;
    hex          = hex_decode(item_i.data_byte);
    new_len      = {(item_i.restart ? 12'd0 : frame_len_q[11:0]), hex.value};

    phase_d      = ph;
    digit_cnt_d  = item_i.restart ? 2'd0 : digit_cnt_q;
    frame_len_d  = item_i.restart ? 16'd0 : frame_len_q;
    bytes_left_d = left;
    cur_chan_d   = cur_chan_q;
    halted_d     = item_i.restart ? 1'b0 : halted_q;

    res              = '0;
    res.kind         = KIND_PAYLOAD;

    if (!halted_d) begin
      unique case (ph)
        PH_HEADER: begin
          if (!hex.ok) begin
            halted_d     = 1'b1;
            digit_cnt_d  = 2'd0;
            frame_len_d  = 16'd0;
            bytes_left_d = 16'd0;
            res.valid    = 1'b1;
            res.kind     = KIND_BAD_DIGIT;
            res.last     = 1'b1;
          end else if (digit_cnt_d != 2'd3) begin
            digit_cnt_d = digit_cnt_d + 2'd1;
            frame_len_d = new_len;
          end else begin
            digit_cnt_d  = 2'd0;
            frame_len_d  = 16'd0;
            bytes_left_d = 16'd0;
            res.last     = 1'b1;
            priority if (new_len == 16'd0) begin
              res.valid = 1'b1;
              res.kind  = KIND_FLUSH;
            end else if (new_len == 16'd1) begin
              res.valid = 1'b1;
              res.kind  = KIND_DELIM;
            end else if (new_len < HDR_LEN || new_len > len_limit_i) begin
              halted_d  = 1'b1;
              res.valid = 1'b1;
              res.kind  = KIND_BAD_LENGTH;
            end else if (new_len == HDR_LEN) begin
              cur_chan_d = 2'd0;
              res.valid  = 1'b1;
              res.kind   = sideband_mode_i ? KIND_EMPTY_SB : KIND_EMPTY;
            end else begin
              cur_chan_d   = 2'd0;
              bytes_left_d = new_len - HDR_LEN;
              phase_d      = sideband_mode_i ? PH_CHANNEL : PH_PAYLOAD;
            end
          end
        end
        PH_CHANNEL: begin
          bytes_left_d = left_m1;
          if (item_i.data_byte >= 8'd1 && item_i.data_byte <= 8'd3) begin
            cur_chan_d = item_i.data_byte[1:0];
            phase_d    = (left_m1 == 16'd0) ? PH_HEADER : PH_PAYLOAD;
          end else begin
            cur_chan_d = 2'd0;
            phase_d    = (left_m1 == 16'd0) ? PH_HEADER : PH_DROP;
            res.valid  = 1'b1;
            res.kind   = KIND_BAD_CHANNEL;
            res.last   = 1'b1;
          end
        end
        PH_DROP: begin
          bytes_left_d = left_m1;
          if (left_m1 == 16'd0) begin
            phase_d = PH_HEADER;
          end
        end
        PH_PAYLOAD: begin
          res.valid        = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = item_i.data_byte;
          res.channel      = cur_chan_q;
          res.last         = (left <= 16'd1);
          if (left <= 16'd1) begin
            phase_d      = PH_HEADER;
            bytes_left_d = 16'd0;
          end else begin
            bytes_left_d = left_m1;
          end
        end
        default: ;
      endcase
    end

    if (!step_i) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      digit_cnt_q  <= 2'd0;
      frame_len_q  <= 16'd0;
      bytes_left_q <= 16'd0;
      cur_chan_q   <= 2'd0;
      halted_q     <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      digit_cnt_q  <= digit_cnt_d;
      frame_len_q  <= frame_len_d;
      bytes_left_q <= bytes_left_d;
      cur_chan_q   <= cur_chan_d;
      halted_q     <= halted_d;
    end
  end

  assign result_o = res;

endmodule

>>> rtl/pld_out_stage.sv
// ----------------------------------------------------------------------------
// pld_out_stage
// Result register toward the output channel.
// ----------------------------------------------------------------------------
module pld_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  pld_pkg::result_t result_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [2:0]       kind_o,
  output logic [7:0]       payload_byte_o,
  output logic [1:0]       channel_o,
  output logic             last_o
);
  import pld_pkg::*;

  logic    valid_q;
  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= result_i.valid;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && result_i.valid) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign kind_o         = 3'(res_q.kind);
  assign payload_byte_o = res_q.payload_byte;
  assign channel_o      = res_q.channel;
  assign last_o         = res_q.last;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pkt_line_deframer_core. Byte streams are built from
// well-formed pkt-line frames, control headers, broken headers and noise, and
// are sent under random valid/ready stalls. An in-bench deframer tracks the
// frame state per accepted item and queues the event each byte should raise;
// every output item is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
module tb_top;
  import pld_pkg::*;

  // two-stage pipe, so the drain wait covers anything still in flight
  localparam int DRAIN_CYCLES     = 8;
  localparam int LONG_HOLD_CYCLES = 120;

  // frame tracking phases of the in-bench deframer
  typedef enum logic [1:0] {
    AT_HEADER,
    AT_CHANNEL,
    IN_PAYLOAD,
    DROPPING
  } rx_phase_e;

  typedef struct {
    kind_e      kind;
    logic [7:0] pbyte;
    logic [1:0] chan;
    logic       last;
  } frame_event_t;

  // --------------------------------------------------------------------------
  // DUT signals, the bench-driven ones known from time zero
  // --------------------------------------------------------------------------
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic        cfg_idx_i      = 1'b0;
  logic [15:0] cfg_wdata_i    = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i    = '0;
  logic        restart_i      = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic [1:0]  channel_o;
  logic        last_o;

  pkt_line_deframer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .channel_o      (channel_o),
    .last_o         (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // bench state
  // --------------------------------------------------------------------------
  frame_event_t pending_events[$];
  frame_event_t head_event;
  int           n_errors      = 0;
  int           n_sent        = 0;
  bit           tx_idle_en    = 1'b1;
  bit           rx_idle_en    = 1'b1;
  bit           long_hold     = 1'b0;
  bit           force_restart = 1'b0;

  // deframer copy: config regs at reset values, frame state idle
  logic [15:0]  mdl_max_len = LEN_LIMIT_RST;
  logic         mdl_sb      = 1'b0;
  rx_phase_e    mdl_phase   = AT_HEADER;
  logic [1:0]   mdl_digits  = '0;
  logic [15:0]  mdl_acc     = '0;
  logic [15:0]  mdl_left    = '0;
  logic [1:0]   mdl_chan    = '0;
  logic         mdl_halted  = 1'b0;

  // --------------------------------------------------------------------------
  // deframer model
  // --------------------------------------------------------------------------
  // {ok, nibble}; upper and lower case letters both decode
  function automatic logic [4:0] hex_digit_value(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return {1'b1, 4'(b - 8'h30)};
    if (b >= 8'h41 && b <= 8'h46) return {1'b1, 4'(b - 8'h37)};
    if (b >= 8'h61 && b <= 8'h66) return {1'b1, 4'(b - 8'h57)};
    return 5'd0;
  endfunction

  function automatic void frame_idle();
    mdl_phase  = AT_HEADER;
    mdl_digits = '0;
    mdl_acc    = '0;
    mdl_left   = '0;
  endfunction

  // advance the frame state by one accepted byte and queue its event, if any
  task automatic deframe_byte(input logic [7:0] b, input logic rs);
    frame_event_t ev;
    logic [4:0]   hv;
    logic [15:0]  len;
    bit           got;
    got = 1'b0;
    ev  = '{KIND_PAYLOAD, 8'h00, 2'd0, 1'b1};
    if (rs) begin
      // restart drops any open frame and clears halt
      mdl_halted = 1'b0;
      frame_idle();
    end
    if (!mdl_halted) begin
      case (mdl_phase)
        AT_HEADER: begin
          hv = hex_digit_value(b);
          if (!hv[4]) begin
            mdl_halted = 1'b1;
            frame_idle();
            ev.kind = KIND_BAD_DIGIT;
            got = 1'b1;
          end else begin
            mdl_acc = {mdl_acc[11:0], hv[3:0]};
            if (mdl_digits < 2'd3) begin
              mdl_digits++;
            end else begin
              len = mdl_acc;
              frame_idle();
              got = 1'b1;
              // flush and delim win over the max length check
              if (len == 16'd0) begin
                ev.kind = KIND_FLUSH;
              end else if (len == 16'd1) begin
                ev.kind = KIND_DELIM;
              end else if (len < 16'd4 || len > mdl_max_len) begin
                mdl_halted = 1'b1;
                ev.kind = KIND_BAD_LENGTH;
              end else begin
                mdl_chan = '0;
                if (len == 16'd4) begin
                  ev.kind = mdl_sb ? KIND_EMPTY_SB : KIND_EMPTY;
                end else begin
                  // side-band mode is latched here, at the last header digit
                  got = 1'b0;
                  mdl_left  = len - 16'd4;
                  mdl_phase = mdl_sb ? AT_CHANNEL : IN_PAYLOAD;
                end
              end
            end
          end
        end
        AT_CHANNEL: begin
          mdl_left = mdl_left - 16'd1;
          if (b >= 8'd1 && b <= 8'd3) begin
            mdl_chan = b[1:0];
            if (mdl_left == 16'd0) frame_idle();
            else mdl_phase = IN_PAYLOAD;
          end else begin
            mdl_chan = '0;
            if (mdl_left == 16'd0) frame_idle();
            else mdl_phase = DROPPING;
            ev.kind = KIND_BAD_CHANNEL;
            got = 1'b1;
          end
        end
        DROPPING: begin
          mdl_left = mdl_left - 16'd1;
          if (mdl_left == 16'd0) frame_idle();
        end
        default: begin
          ev  = '{KIND_PAYLOAD, b, mdl_chan, mdl_left < 16'd2};
          got = 1'b1;
          if (mdl_left < 16'd2) frame_idle();
          else mdl_left = mdl_left - 16'd1;
        end
      endcase
    end
    if (got) pending_events = {pending_events, ev};
  endtask

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] b, input logic rs);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    restart_i   <= rs;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    deframe_byte(b, rs);
    n_sent++;
  endtask

  // letters come out in random case
  function automatic logic [7:0] hex_ascii(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h37 : 8'h57) + n;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    logic [4:0] hv;
    do begin
      b  = 8'($urandom_range(0, 255));
      hv = hex_digit_value(b);
    end while (hv[4]);
    return b;
  endfunction

  task automatic send_header(input logic [15:0] len, input logic rs);
    for (int i = 3; i >= 0; i--) send_item(hex_ascii(len[4*i +: 4]), (i == 3) ? rs : 1'b0);
  endtask

  // header plus body; first is the channel byte in side-band mode
  task automatic send_frame(input int len, input logic rs, input logic [7:0] first);
    send_header(16'(len), rs);
    for (int i = 0; i < len - 4; i++) send_item((i == 0) ? first : 8'($urandom_range(0, 255)), 1'b0);
  endtask

  // no item in flight, nothing left to arrive
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_LEN_LIMIT) mdl_max_len = val;
    else mdl_sb = val[0];
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // receiver side: random ready bursts, plus one long hold-off on request
  // --------------------------------------------------------------------------
  always begin
    @(posedge clk_i);
    if (long_hold) begin
      out_ready_i <= 1'b0;
      repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      long_hold = 1'b0;
      out_ready_i <= 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected item kind %0d byte %02h chan %0d last %0b",
                                  kind_o, payload_byte_o, channel_o, last_o));
      end else begin
        head_event = pending_events.pop_front();
        if (kind_o !== head_event.kind)
          report_mismatch($sformatf("kind %0d, want %s", kind_o, head_event.kind.name()));
        if (payload_byte_o !== head_event.pbyte)
          report_mismatch($sformatf("payload_byte %02h, want %02h", payload_byte_o,
                                    head_event.pbyte));
        if (channel_o !== head_event.chan)
          report_mismatch($sformatf("channel %0d, want %0d", channel_o, head_event.chan));
        if (last_o !== head_event.last)
          report_mismatch($sformatf("last %0b, want %0b", last_o, head_event.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // flush, delim, empty, short and single-byte frames, over-length at reset max
  task automatic test_control_frames();
    send_header(16'd0, 1'b1);
    send_header(16'd1, 1'b0);
    send_header(16'd4, 1'b0);
    send_frame(10, 1'b0, 8'hFF);
    send_frame(5, 1'b0, 8'h00);
    send_header(16'hFFF1, 1'b0);
    send_item(8'h30, 1'b0);          // ignored while halted
    send_header(16'd0, 1'b1);
  endtask

  // non-hex bytes just outside each digit range, plus 00 and FF, at each header position
  task automatic test_bad_digit();
    logic [7:0] bad [8] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h00, 8'hFF};
    int         k;
    for (int i = 0; i < 8; i++) begin
      k = i % 4;
      for (int j = 0; j < k; j++) send_item(8'h30, j == 0);
      send_item(bad[i], k == 0);
      send_item(8'h30, 1'b0);
    end
    send_header(16'd1, 1'b1);
  endtask

  // lengths 2 and 3, length limit at 4, at 0 and at its top with a restart mid-frame
  task automatic test_bad_length();
    send_header(16'd2, 1'b1);
    send_header(16'd3, 1'b1);
    write_reg(CFG_LEN_LIMIT, 16'd4);
    send_header(16'd4, 1'b1);
    send_header(16'd5, 1'b0);
    write_reg(CFG_LEN_LIMIT, 16'd0);
    send_header(16'd0, 1'b1);
    send_header(16'd1, 1'b0);
    send_header(16'd4, 1'b0);
    write_reg(CFG_LEN_LIMIT, 16'hFFFF);
    send_header(16'hFFFF, 1'b1);
    repeat (3) send_item(8'($urandom_range(0, 255)), 1'b0);
    send_header(16'd0, 1'b1);
    write_reg(CFG_LEN_LIMIT, LEN_LIMIT_RST);
  endtask

  task automatic test_sideband();
    write_reg(CFG_SIDEBAND_MODE, 16'd1);
    send_header(16'd4, 1'b1);        // empty side-band frame
    send_frame(5, 1'b0, 8'd2);       // channel byte only, silent
    send_frame(5, 1'b0, 8'd0);
    send_frame(8, 1'b0, 8'd4);       // rest of frame dropped
    send_frame(6, 1'b0, 8'hFF);
    send_frame(7, 1'b0, 8'd1);
    send_frame(7, 1'b0, 8'd2);
    send_frame(7, 1'b0, 8'd3);
    send_header(16'd0, 1'b0);
  endtask

  // mode changes mid-frame only apply from the next header
  task automatic test_mode_sampling();
    write_reg(CFG_SIDEBAND_MODE, 16'd0);
    send_header(16'd8, 1'b1);
    write_reg(CFG_SIDEBAND_MODE, 16'd1);
    repeat (4) send_item(8'($urandom_range(0, 255)), 1'b0);
    send_frame(6, 1'b0, 8'd3);
    send_header(16'd7, 1'b0);
    send_item(8'd2, 1'b0);
    write_reg(CFG_SIDEBAND_MODE, 16'd0);
    repeat (2) send_item(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // output held off long enough for both pipe stages to fill and stall intake
  task automatic test_pressure();
    wait_drain();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    long_hold  = 1'b1;
    send_frame(60, 1'b1, 8'($urandom_range(0, 255)));
    wait_drain();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // mostly well-formed frames with random content, the rest broken or noise
  task automatic run_random_phase(input logic [15:0] max_len, input logic sb,
                                  input int goal, input bit idling);
    int         stop_at, r, len, lim, k;
    logic       rs;
    logic [7:0] first;
    write_reg(CFG_LEN_LIMIT, max_len);
    write_reg(CFG_SIDEBAND_MODE, {15'd0, sb});
    stop_at = n_sent + goal;
    while (n_sent < stop_at) begin
      tx_idle_en = idling && ($urandom_range(0, 3) != 0);
      rx_idle_en = idling && ($urandom_range(0, 3) != 0);
      rs = mdl_halted || force_restart || ($urandom_range(0, 15) == 0);
      force_restart = 1'b0;
      r   = $urandom_range(0, 99);
      lim = (mdl_max_len < 16'd30) ? int'(mdl_max_len) : 30;
      if (r < 60 && lim >= 5) begin
        if (r < 3 && mdl_max_len > 16'd30)
          len = $urandom_range(31, (mdl_max_len < 16'd300) ? int'(mdl_max_len) : 300);
        else
          len = $urandom_range(5, lim);
        if (mdl_sb && $urandom_range(0, 7) != 0) first = 8'($urandom_range(1, 3));
        else first = 8'($urandom_range(0, 255));
        send_frame(len, rs, first);
      end else if (r < 72) begin
        case ($urandom_range(0, 2))
          0:       len = 0;
          1:       len = 1;
          default: len = 4;
        endcase
        send_header(16'(len), rs);
      end else if (r < 79) begin
        if (mdl_max_len < 16'hFFFF && $urandom_range(0, 1))
          len = $urandom_range(int'(mdl_max_len) + 1, 65535);
        else
          len = $urandom_range(2, 3);
        send_header(16'(len), rs);
      end else if (r < 86) begin
        k = $urandom_range(0, 3);
        for (int j = 0; j < k; j++)
          send_item(hex_ascii(4'($urandom_range(0, 15))), (j == 0) ? rs : 1'b0);
        send_item(non_hex_byte(), (k == 0) ? rs : 1'b0);
        repeat ($urandom_range(0, 3)) send_item(8'($urandom_range(0, 255)), 1'b0);
      end else if (r < 93 && lim >= 6) begin
        // frame cut short; the next one opens with a restart
        len = $urandom_range(6, lim);
        send_header(16'(len), rs);
        repeat ($urandom_range(0, len - 5)) send_item(8'($urandom_range(0, 255)), 1'b0);
        force_restart = 1'b1;
      end else begin
        send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  task automatic test_random();
    run_random_phase(LEN_LIMIT_RST, 1'b0, 250, 1'b1);
    run_random_phase(16'($urandom_range(4, 40)), 1'b1, 250, 1'b1);
    run_random_phase(16'hFFFF, 1'b1, 220, 1'b1);
    run_random_phase(16'($urandom_range(0, 3)), 1'b0, 100, 1'b1);
    // closing stretch runs with no stalls on either side
    run_random_phase(16'($urandom_range(5, 300)), 1'b0, 260, 1'b0);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_control_frames();
    test_bad_digit();
    test_bad_length();
    test_sideband();
    test_mode_sampling();
    test_pressure();
    test_random();
    wait_drain();
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
